FILE: design/lion_pkg.sv
// Shared constants and register codes for the Lion optimizer update unit.
package lion_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS   = 24;

    localparam int CFG_W        = 25;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    localparam logic [CFG_W-1:0] LR_RESET    = CFG_W'(1678);
    localparam logic [CFG_W-1:0] BETA1_RESET = CFG_W'(15099494);
    localparam logic [CFG_W-1:0] BETA2_RESET = CFG_W'(16609444);
    localparam logic [CFG_W-1:0] WD_RESET    = CFG_W'(0);

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_INTERP_BETA   = 2'd1,
        REG_MOMENTUM_BETA = 2'd2,
        REG_WEIGHT_DECAY  = 2'd3
    } reg_index_t;

endpackage

FILE: design/lion_optimizer_update_unit.sv
// Lion optimizer update: five-stage pipeline with APB coefficient registers.
// An accepted input request passes through stages 1 to 5 in order; m_tvalid is the stage 5 valid bit.
// Throughput: one element per cycle while the output is not stalled; five 32x26 multipliers in stage 1 and
// one 35x26 multiplier in stage 4 each take a stage of their own.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// coefficient registers with their reset values.
module lion_optimizer_update_unit #(
    parameter int VALUE_WIDTH = lion_pkg::DEFAULT_VALUE_WIDTH,
    parameter int FRAC_BITS   = lion_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input request: param_in, momentum_in, grad_in (lowest bits first)
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // result: param_out, momentum_out (lowest bits first)
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]   m_tdata,
    // result flag: saturated
    output logic                                 m_tuser,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lion_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lion_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lion_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import lion_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((2*VW+7)/8)*8;
    localparam int CW    = F + 1;                 // clamped coefficient, 0..1.0
    localparam int MW    = (CFG_W > CW) ? CFG_W : CW;
    localparam int PW    = VW + CW + 1;           // value times coefficient
    localparam int RW    = PW - F;                // rounded product
    localparam int TW    = RW + 1;                // sign plus decay term
    localparam int LW    = TW + CW + 1;           // term times learning rate
    localparam int RLW   = LW - F;
    localparam int PNW   = RLW + 1;

    localparam logic [MW-1:0]        ONE_M  = MW'(1) << F;
    localparam logic [CW-1:0]        ONE_C  = CW'(1) << F;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);
    localparam logic signed [LW-1:0] HALF_L = LW'(1) << (F - 1);
    localparam logic signed [TW-1:0] ONE_T  = TW'(1) << F;
    localparam logic signed [VW-1:0] VMAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN   = {1'b1, {(VW-1){1'b0}}};

    // Clamp a raw register value to 1.0.
    function automatic logic [CW-1:0] clamp_coef(input logic [CFG_W-1:0] w);
        logic [MW-1:0] w_ext;
        w_ext = MW'(w);
        return (w_ext > ONE_M) ? ONE_C : w_ext[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: raw value for readback plus clamped
    // coefficients and their complements, updated on each write.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] lr_raw_reg, b1_raw_reg, b2_raw_reg, wd_raw_reg;
    logic [CW-1:0]    lr_reg, b1_reg, b1n_reg, b2_reg, b2n_reg, wd_reg;
    logic [CFG_W-1:0] wr_value;
    logic [CW-1:0]    wr_coef;
    reg_index_t       wr_index;
    logic             wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_index = reg_index_t'(paddr[3:2]);
    assign wr_value = pwdata[CFG_W-1:0];
    assign wr_coef  = clamp_coef(wr_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_raw_reg <= LR_RESET;
            b1_raw_reg <= BETA1_RESET;
            b2_raw_reg <= BETA2_RESET;
            wd_raw_reg <= WD_RESET;
            lr_reg     <= clamp_coef(LR_RESET);
            b1_reg     <= clamp_coef(BETA1_RESET);
            b1n_reg    <= ONE_C - clamp_coef(BETA1_RESET);
            b2_reg     <= clamp_coef(BETA2_RESET);
            b2n_reg    <= ONE_C - clamp_coef(BETA2_RESET);
            wd_reg     <= clamp_coef(WD_RESET);
        end else if (wr_en) begin
            case (wr_index)
                REG_LEARNING_RATE: begin
                    lr_raw_reg <= wr_value;
                    lr_reg     <= wr_coef;
                end
                REG_INTERP_BETA: begin
                    b1_raw_reg <= wr_value;
                    b1_reg     <= wr_coef;
                    b1n_reg    <= ONE_C - wr_coef;
                end
                REG_MOMENTUM_BETA: begin
                    b2_raw_reg <= wr_value;
                    b2_reg     <= wr_coef;
                    b2n_reg    <= ONE_C - wr_coef;
                end
                REG_WEIGHT_DECAY: begin
                    wd_raw_reg <= wr_value;
                    wd_reg     <= wr_coef;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (wr_index)
            REG_LEARNING_RATE: prdata = APB_DATA_W'(lr_raw_reg);
            REG_INTERP_BETA:   prdata = APB_DATA_W'(b1_raw_reg);
            REG_MOMENTUM_BETA: prdata = APB_DATA_W'(b2_raw_reg);
            REG_WEIGHT_DECAY:  prdata = APB_DATA_W'(wd_raw_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together; hold all stages
    // while a finished result waits at the output.
    // ------------------------------------------------------------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign adv      = !v5_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the five coefficient products.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] p_in, m_in, g_in;
    logic signed [CW:0]   b1_s, b1n_s, b2_s, b2n_s, wd_s;
    logic signed [PW-1:0] mb1_next, gb1_next, mb2_next, gb2_next, pwd_next;
    logic signed [PW-1:0] mb1_reg, gb1_reg, mb2_reg, gb2_reg, pwd_reg;
    logic signed [VW-1:0] p1_reg;

    assign p_in  = s_tdata[VW-1:0];
    assign m_in  = s_tdata[2*VW-1:VW];
    assign g_in  = s_tdata[3*VW-1:2*VW];
    assign b1_s  = {1'b0, b1_reg};
    assign b1n_s = {1'b0, b1n_reg};
    assign b2_s  = {1'b0, b2_reg};
    assign b2n_s = {1'b0, b2n_reg};
    assign wd_s  = {1'b0, wd_reg};

    assign mb1_next = m_in * b1_s;
    assign gb1_next = g_in * b1n_s;
    assign mb2_next = m_in * b2_s;
    assign gb2_next = g_in * b2n_s;
    assign pwd_next = p_in * wd_s;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg  <= p_in;
            mb1_reg <= mb1_next;
            gb1_reg <= gb1_next;
            mb2_reg <= mb2_next;
            gb2_reg <= gb2_next;
            pwd_reg <= pwd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round each product to nearest (add half, floor).
    // ------------------------------------------------------------------
    logic signed [PW-1:0] mb1_h, gb1_h, mb2_h, gb2_h, pwd_h;
    logic signed [RW-1:0] rmb1_reg, rgb1_reg, rmb2_reg, rgb2_reg, rpwd_reg;
    logic signed [VW-1:0] p2_reg;

    assign mb1_h = mb1_reg + HALF_P;
    assign gb1_h = gb1_reg + HALF_P;
    assign mb2_h = mb2_reg + HALF_P;
    assign gb2_h = gb2_reg + HALF_P;
    assign pwd_h = pwd_reg + HALF_P;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg   <= p1_reg;
            rmb1_reg <= mb1_h[PW-1:F];
            rgb1_reg <= gb1_h[PW-1:F];
            rmb2_reg <= mb2_h[PW-1:F];
            rgb2_reg <= gb2_h[PW-1:F];
            rpwd_reg <= pwd_h[PW-1:F];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: interp sign picks one of three precomputed decay terms;
    // form the momentum sum alongside.
    // ------------------------------------------------------------------
    logic signed [RW:0]   interp, mn_next;
    logic signed [TW-1:0] term_pos, term_neg, term_zero, term_next;
    logic signed [TW-1:0] term3_reg;
    logic signed [RW:0]   mn3_reg;
    logic signed [VW-1:0] p3_reg;

    assign interp    = (RW+1)'(rmb1_reg) + (RW+1)'(rgb1_reg);
    assign mn_next   = (RW+1)'(rmb2_reg) + (RW+1)'(rgb2_reg);
    assign term_pos  = TW'(rpwd_reg) + ONE_T;
    assign term_neg  = TW'(rpwd_reg) - ONE_T;
    assign term_zero = TW'(rpwd_reg);

    always_comb begin
        if (interp[RW]) begin
            term_next = term_neg;
        end else if (interp != '0) begin
            term_next = term_pos;
        end else begin
            term_next = term_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_reg    <= p2_reg;
            term3_reg <= term_next;
            mn3_reg   <= mn_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the term by the learning rate; saturate momentum.
    // ------------------------------------------------------------------
    logic signed [CW:0]   lr_s;
    logic signed [LW-1:0] step_next, step4_reg;
    logic signed [VW-1:0] p4_reg, mn4_reg;
    logic                 mn_sat, mn4_sat_reg;
    logic signed [VW-1:0] mn_clip;

    assign lr_s      = {1'b0, lr_reg};
    assign step_next = term3_reg * lr_s;

    always_comb begin
        mn_sat  = 1'b1;
        mn_clip = mn3_reg[VW-1:0];
        if (mn3_reg > VMAX) begin
            mn_clip = VMAX;
        end else if (mn3_reg < VMIN) begin
            mn_clip = VMIN;
        end else begin
            mn_sat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_reg      <= p3_reg;
            step4_reg   <= step_next;
            mn4_reg     <= mn_clip;
            mn4_sat_reg <= mn_sat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: round the step, subtract from the parameter, saturate.
    // This is the output register.
    // ------------------------------------------------------------------
    logic signed [LW-1:0]  step_h;
    logic signed [RLW-1:0] step_r;
    logic signed [PNW-1:0] pn;
    logic signed [VW-1:0]  pn_clip;
    logic                  pn_sat;
    logic signed [VW-1:0]  param_reg, mom_reg;
    logic                  sat_reg;

    assign step_h = step4_reg + HALF_L;
    assign step_r = step_h[LW-1:F];
    assign pn     = PNW'(p4_reg) - PNW'(step_r);

    always_comb begin
        pn_sat  = 1'b1;
        pn_clip = pn[VW-1:0];
        if (pn > VMAX) begin
            pn_clip = VMAX;
        end else if (pn < VMIN) begin
            pn_clip = VMIN;
        end else begin
            pn_sat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            param_reg <= pn_clip;
            mom_reg   <= mn4_reg;
            sat_reg   <= pn_sat || mn4_sat_reg;
        end
    end

    assign m_tdata = OUT_W'({mom_reg, param_reg});
    assign m_tuser = sat_reg;

endmodule
